// ===== hw/rtl/btpc_pkg.sv =====
// shared types and constants for the barometric compensation unit
`default_nettype none

package btpc_pkg;

    localparam int unsigned NUM_CFG   = 6;
    localparam int unsigned ADDR_W    = 5;
    localparam int unsigned RAW_W     = 24;
    localparam int unsigned COEF_W    = 16;
    localparam int unsigned DT_W      = 26;
    localparam int unsigned TEMP_W    = 19;
    localparam int unsigned ACC_W     = 64;
    localparam int unsigned MPLIER_W  = 25;
    localparam int unsigned TERM_W    = 48;
    localparam int unsigned RES_W     = 32;

    // register indexes
    localparam logic [2:0] IDX_SENS_BASE = 3'd0;
    localparam logic [2:0] IDX_OFF_BASE  = 3'd1;
    localparam logic [2:0] IDX_SENS_TC   = 3'd2;
    localparam logic [2:0] IDX_OFF_TC    = 3'd3;
    localparam logic [2:0] IDX_REF_TEMP  = 3'd4;
    localparam logic [2:0] IDX_TEMP_SLP  = 3'd5;

    // item kinds
    localparam logic OP_TEMP = 1'b0;
    localparam logic OP_PRES = 1'b1;

    localparam logic signed [TEMP_W-1:0] TEMP_REF   = 19'sd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_VLOW  = -19'sd1500;
    localparam logic signed [TEMP_W:0]   N_REF      = 20'sd2000;
    localparam logic signed [TEMP_W:0]   N_VLOW     = 20'sd1500;
    localparam logic signed [ACC_W-1:0]  SAT_MAX    = 64'sd2147483647;
    localparam logic signed [ACC_W-1:0]  SAT_MIN    = -64'sd2147483648;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_POST = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    // which product the shared multiplier is working on
    typedef enum logic [2:0] {
        STEP_T1    = 3'd0,
        STEP_T2    = 3'd1,
        STEP_OFF   = 3'd2,
        STEP_SENS  = 3'd3,
        STEP_SQ1   = 3'd4,
        STEP_SQ2   = 3'd5,
        STEP_LOADP = 3'd6,
        STEP_FIN   = 3'd7
    } step_t;

endpackage

`default_nettype wire

// ===== hw/rtl/baro_temp_pressure_compensation_unit.sv =====
// barometric sensor compensation: shift-add multiplier with a step sequencer
// the time from accept to result valid is set by the bit-serial multiplier, one multiplier bit per
// cycle, with early exit once the remaining multiplier bits are zero
// throughput: one transaction at a time, the next input is taken the cycle after the result is queued
// reset: asynchronous active low; clears config registers, output valid, stored dt and temperature
`default_nettype none

module baro_temp_pressure_compensation_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [23:0] raw_sample
    input  wire logic        s_tuser,   // [0] operation
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] compensated_value
    output logic             m_tuser,   // [0] result_kind
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    btpc_pkg::state_t state_reg, state_next;
    btpc_pkg::step_t  step_reg, step_next;

    logic [btpc_pkg::COEF_W-1:0]          cfg_reg [btpc_pkg::NUM_CFG];
    logic signed [btpc_pkg::DT_W-1:0]     dt_reg, dt_next;
    logic signed [btpc_pkg::TEMP_W-1:0]   temp_reg, temp_next;
    logic [btpc_pkg::RAW_W-1:0]           raw_reg, raw_next;
    logic                                 kind_reg, kind_next;
    logic signed [btpc_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic signed [btpc_pkg::ACC_W-1:0]    mcand_reg, mcand_next;
    logic [btpc_pkg::MPLIER_W-1:0]        mplier_reg, mplier_next;
    logic signed [btpc_pkg::TERM_W-1:0]   off_reg, off_next;
    logic signed [btpc_pkg::TERM_W-1:0]   sens_reg, sens_next;
    logic [btpc_pkg::RES_W-1:0]           res_reg, res_next;
    logic                                 m_tvalid_reg, m_tvalid_next;
    logic [btpc_pkg::RES_W-1:0]           m_tdata_reg, m_tdata_next;
    logic                                 m_tuser_reg, m_tuser_next;

    logic                                 accept;
    logic                                 cfg_wr;
    logic [2:0]                           cfg_idx;
    logic signed [btpc_pkg::DT_W-1:0]     dt_new;
    logic [btpc_pkg::DT_W-1:0]            dt_abs;
    logic signed [btpc_pkg::ACC_W-1:0]    dt_ext;
    logic signed [btpc_pkg::ACC_W-1:0]    temp_wide;
    logic signed [btpc_pkg::TEMP_W-1:0]   temp1;
    logic signed [btpc_pkg::TEMP_W:0]     n_lo;
    logic signed [btpc_pkg::TEMP_W:0]     n_vlo;
    logic [btpc_pkg::TEMP_W:0]            n_lo_abs;
    logic [btpc_pkg::TEMP_W:0]            n_vlo_abs;
    logic signed [btpc_pkg::TERM_W-1:0]   n2;
    logic signed [btpc_pkg::TERM_W-1:0]   f5;
    logic signed [btpc_pkg::TERM_W-1:0]   f7;
    logic signed [btpc_pkg::TERM_W-1:0]   f11;
    logic signed [btpc_pkg::ACC_W-1:0]    p_full;

    assign s_tready = (state_reg == btpc_pkg::ST_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_comb
    begin
        if (cfg_idx < 3'(btpc_pkg::NUM_CFG))
        begin
            prdata = {16'h0000, cfg_reg[cfg_idx]};
        end
        else
        begin
            prdata = 32'h0000_0000;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < btpc_pkg::NUM_CFG; i++)
            begin
                cfg_reg[i] <= '0;
            end
        end
        else if (cfg_wr && (cfg_idx < 3'(btpc_pkg::NUM_CFG)))
        begin
            cfg_reg[cfg_idx] <= pwdata[15:0];
        end
    end

    // datapath helpers
    assign dt_new = $signed({2'b00, s_tdata})
                  - $signed({2'b00, cfg_reg[btpc_pkg::IDX_REF_TEMP], 8'h00});
    assign dt_abs = dt_reg[btpc_pkg::DT_W-1] ? 26'(-dt_reg) : dt_reg;
    assign dt_ext = {{(btpc_pkg::ACC_W-btpc_pkg::DT_W){dt_reg[btpc_pkg::DT_W-1]}}, dt_reg};

    assign temp_wide = 64'(btpc_pkg::TEMP_REF) + (acc_reg >>> 23);
    assign temp1     = temp_wide[btpc_pkg::TEMP_W-1:0];

    assign n_lo      = {temp_reg[btpc_pkg::TEMP_W-1], temp_reg} - btpc_pkg::N_REF;
    assign n_vlo     = {temp_reg[btpc_pkg::TEMP_W-1], temp_reg} + btpc_pkg::N_VLOW;
    assign n_lo_abs  = n_lo[btpc_pkg::TEMP_W] ? 20'(-n_lo) : n_lo;
    assign n_vlo_abs = n_vlo[btpc_pkg::TEMP_W] ? 20'(-n_vlo) : n_vlo;

    // squares are non-negative and below 2^40
    assign n2  = acc_reg[btpc_pkg::TERM_W-1:0];
    assign f5  = n2 + (n2 <<< 2);
    assign f7  = (n2 <<< 3) - n2;
    assign f11 = (n2 <<< 3) + (n2 <<< 1) + n2;

    assign p_full = ((acc_reg >>> 21)
                  - $signed({{(btpc_pkg::ACC_W-btpc_pkg::TERM_W){off_reg[btpc_pkg::TERM_W-1]}},
                             off_reg})) >>> 15;

    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        dt_next       = dt_reg;
        temp_next     = temp_reg;
        raw_next      = raw_reg;
        kind_next     = kind_reg;
        acc_next      = acc_reg;
        mcand_next    = mcand_reg;
        mplier_next   = mplier_reg;
        off_next      = off_reg;
        sens_next     = sens_reg;
        res_next      = res_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            btpc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next = s_tuser;
                    raw_next  = s_tdata;
                    acc_next  = '0;
                    state_next = btpc_pkg::ST_MUL;
                    if (s_tuser == btpc_pkg::OP_TEMP)
                    begin
                        dt_next     = dt_new;
                        mcand_next  = {{(btpc_pkg::ACC_W-btpc_pkg::DT_W){dt_new[25]}}, dt_new};
                        mplier_next = {9'h000, cfg_reg[btpc_pkg::IDX_TEMP_SLP]};
                        step_next   = btpc_pkg::STEP_T1;
                    end
                    else
                    begin
                        mcand_next  = dt_ext;
                        mplier_next = {9'h000, cfg_reg[btpc_pkg::IDX_OFF_TC]};
                        step_next   = btpc_pkg::STEP_OFF;
                    end
                end
            end

            btpc_pkg::ST_MUL:
            begin
                // one multiplier bit per cycle, stop when no set bits remain
                if (mplier_reg == '0)
                begin
                    state_next = btpc_pkg::ST_POST;
                end
                else
                begin
                    if (mplier_reg[0])
                    begin
                        acc_next = acc_reg + mcand_reg;
                    end
                    mcand_next  = mcand_reg <<< 1;
                    mplier_next = mplier_reg >> 1;
                end
            end

            btpc_pkg::ST_POST:
            begin
                unique case (step_reg)
                    btpc_pkg::STEP_T1:
                    begin
                        temp_next = temp1;
                        if (temp1 < btpc_pkg::TEMP_REF)
                        begin
                            acc_next    = '0;
                            mcand_next  = {39'h0, dt_abs[24:0]};
                            mplier_next = dt_abs[24:0];
                            step_next   = btpc_pkg::STEP_T2;
                            state_next  = btpc_pkg::ST_MUL;
                        end
                        else
                        begin
                            res_next   = {{13{temp1[btpc_pkg::TEMP_W-1]}}, temp1};
                            state_next = btpc_pkg::ST_DONE;
                        end
                    end

                    btpc_pkg::STEP_T2:
                    begin
                        res_next   = {{13{temp_reg[btpc_pkg::TEMP_W-1]}}, temp_reg}
                                   - {14'h0, acc_reg[48:31]};
                        state_next = btpc_pkg::ST_DONE;
                    end

                    btpc_pkg::STEP_OFF:
                    begin
                        off_next    = $signed({16'h0, cfg_reg[btpc_pkg::IDX_OFF_BASE], 16'h0})
                                    + $signed(acc_reg[54:7]);
                        acc_next    = '0;
                        mcand_next  = dt_ext;
                        mplier_next = {9'h000, cfg_reg[btpc_pkg::IDX_SENS_TC]};
                        step_next   = btpc_pkg::STEP_SENS;
                        state_next  = btpc_pkg::ST_MUL;
                    end

                    btpc_pkg::STEP_SENS:
                    begin
                        sens_next = $signed({17'h0, cfg_reg[btpc_pkg::IDX_SENS_BASE], 15'h0})
                                  + $signed(acc_reg[55:8]);
                        if (temp_reg < btpc_pkg::TEMP_REF)
                        begin
                            acc_next    = '0;
                            mcand_next  = {44'h0, n_lo_abs};
                            mplier_next = {5'h00, n_lo_abs};
                            step_next   = btpc_pkg::STEP_SQ1;
                            state_next  = btpc_pkg::ST_MUL;
                        end
                        else
                        begin
                            step_next = btpc_pkg::STEP_LOADP;
                        end
                    end

                    btpc_pkg::STEP_SQ1:
                    begin
                        off_next  = off_reg - (f5 >>> 1);
                        sens_next = sens_reg - (f5 >>> 2);
                        if (temp_reg < btpc_pkg::TEMP_VLOW)
                        begin
                            acc_next    = '0;
                            mcand_next  = {44'h0, n_vlo_abs};
                            mplier_next = {5'h00, n_vlo_abs};
                            step_next   = btpc_pkg::STEP_SQ2;
                            state_next  = btpc_pkg::ST_MUL;
                        end
                        else
                        begin
                            step_next = btpc_pkg::STEP_LOADP;
                        end
                    end

                    btpc_pkg::STEP_SQ2:
                    begin
                        off_next  = off_reg - f7;
                        sens_next = sens_reg - (f11 >>> 1);
                        step_next = btpc_pkg::STEP_LOADP;
                    end

                    btpc_pkg::STEP_LOADP:
                    begin
                        acc_next    = '0;
                        mcand_next  = {{(btpc_pkg::ACC_W-btpc_pkg::TERM_W){
                                        sens_reg[btpc_pkg::TERM_W-1]}}, sens_reg};
                        mplier_next = {1'b0, raw_reg};
                        step_next   = btpc_pkg::STEP_FIN;
                        state_next  = btpc_pkg::ST_MUL;
                    end

                    btpc_pkg::STEP_FIN:
                    begin
                        if (p_full > btpc_pkg::SAT_MAX)
                        begin
                            res_next = btpc_pkg::SAT_MAX[31:0];
                        end
                        else if (p_full < btpc_pkg::SAT_MIN)
                        begin
                            res_next = btpc_pkg::SAT_MIN[31:0];
                        end
                        else
                        begin
                            res_next = p_full[31:0];
                        end
                        state_next = btpc_pkg::ST_DONE;
                    end

                    default:
                    begin
                        state_next = btpc_pkg::ST_DONE;
                    end
                endcase
            end

            btpc_pkg::ST_DONE:
            begin
                // hand the result to the output register once it is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_reg;
                    m_tuser_next  = kind_reg;
                    state_next    = btpc_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = btpc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= btpc_pkg::ST_IDLE;
            step_reg     <= btpc_pkg::STEP_T1;
            dt_reg       <= '0;
            temp_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            dt_reg       <= dt_next;
            temp_reg     <= temp_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        raw_reg     <= raw_next;
        kind_reg    <= kind_next;
        acc_reg     <= acc_next;
        mcand_reg   <= mcand_next;
        mplier_reg  <= mplier_next;
        off_reg     <= off_next;
        sens_reg    <= sens_next;
        res_reg     <= res_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

`ifndef SYNTH
    a_mul_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == btpc_pkg::ST_MUL) && (mplier_reg == '0)
        |=> (state_reg == btpc_pkg::ST_POST))
        else $error("multiplier did not hand over to post step");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == btpc_pkg::ST_MUL))
        else $error("accepted transaction did not start the multiplier");

    a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == btpc_pkg::ST_DONE) && m_tvalid_reg && !m_tready
        |=> (state_reg == btpc_pkg::ST_DONE))
        else $error("result dropped while output stalled");

    a_square_sign: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == btpc_pkg::ST_POST) && (step_reg == btpc_pkg::STEP_T2)
        |-> !acc_reg[btpc_pkg::ACC_W-1])
        else $error("dt square came out negative");
`endif

endmodule

`default_nettype wire
